[hw/rtl/rpnh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnh_pkg : shared types and constants of the ray/polygon nearest-hit block
// Word layouts, arithmetic widths, register indexes and small helpers.
// ----------------------------------------------------------------------------
package rpnh_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int COUNT_W      = 5;
   localparam int COORD_W      = 32;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int MUL_W        = DIFF_W + 2;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int CROSS_W      = 68;
   localparam int HALF_W       = CROSS_W / 2;
   localparam int QUO_W        = 34;
   localparam int NUM_W        = CROSS_W + QUO_W;
   localparam int ROOT_W       = 34;
   localparam int SQV_W        = 2 * ROOT_W;
   localparam int OFS_W        = 31;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_W        = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_X        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_Y        = 2'd2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_CAST = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [MUL_W-1:0]   op_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [CROSS_W-1:0] cross_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] vertex_index;
      coord_type  vertex_x;
      coord_type  vertex_y;
      coord_type  ray_start_x;
      coord_type  ray_start_y;
      coord_type  ray_end_x;
      coord_type  ray_end_y;
      coord_type  best_x;
      coord_type  best_y;
   } req_type;

   typedef struct packed {
      logic             hit;
      coord_type        hit_x;
      coord_type        hit_y;
      coord_type        wall_start_x;
      coord_type        wall_start_y;
      coord_type        wall_end_x;
      coord_type        wall_end_y;
      logic [OFS_W-1:0] wall_offset;
   } rsp_type;

   // Signed difference of two coordinates, one bit wider so it never wraps.
   function automatic diff_type dif(input coord_type a, input coord_type b);
      return DIFF_W'(a) - DIFF_W'(b);
   endfunction

   // Object position plus a relative vertex, clamped to the 32-bit range.
   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      logic signed [COORD_W:0] s;
      s = (COORD_W+1)'(a) + (COORD_W+1)'(b);
      if (s[COORD_W] != s[COORD_W-1]) begin
         return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end
      return s[COORD_W-1:0];
   endfunction

   // Strictly opposite sides: both non-zero and of different sign.
   function automatic logic opposite(input cross_type a, input cross_type b);
      return (a != '0) && (b != '0) && (a[CROSS_W-1] != b[CROSS_W-1]);
   endfunction

endpackage

[hw/rtl/rpnh_vstore.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnh_vstore : polygon vertex store
// One write port for vertex loads, one registered read port for the walk.
// ----------------------------------------------------------------------------
module rpnh_vstore (
   input  logic                       clock,
   input  logic                       we,
   input  logic [rpnh_pkg::IDX_W-1:0] waddr,
   input  rpnh_pkg::coord_type        wdata_x,
   input  rpnh_pkg::coord_type        wdata_y,
   input  logic [rpnh_pkg::IDX_W-1:0] raddr,
   output rpnh_pkg::coord_type        rdata_x,
   output rpnh_pkg::coord_type        rdata_y
);
   import rpnh_pkg::*;

   logic [2*COORD_W-1:0] mem [MAX_VERTICES];
   logic [2*COORD_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= {wdata_x, wdata_y};
      end
      rd_ff <= mem[raddr];
   end

   assign rdata_x = rd_ff[2*COORD_W-1:COORD_W];
   assign rdata_y = rd_ff[COORD_W-1:0];

endmodule

[hw/rtl/rpnh_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnh_mul : shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module rpnh_mul (
   input  logic               clock,
   input  rpnh_pkg::op_type   op_a,
   input  rpnh_pkg::op_type   op_b,
   output rpnh_pkg::prod_type prod
);
   import rpnh_pkg::*;

   prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

[hw/rtl/rpnh_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnh_div : restoring divider for the crossing ratio
// One quotient bit per cycle; the quotient is known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
module rpnh_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rpnh_pkg::NUM_W-1:0]   num,
   input  logic [rpnh_pkg::CROSS_W-1:0] den,
   output logic                         done,
   output logic [rpnh_pkg::QUO_W-1:0]   quo
);
   import rpnh_pkg::*;

   localparam int CW = $clog2(QUO_W + 1);

   logic [CROSS_W-1:0] rem_ff, rem_in;
   logic [CROSS_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0]   sh_ff, sh_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CROSS_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, sh_ff[QUO_W-1]};
      if (start) begin
         rem_in = num[NUM_W-1:QUO_W];
         sh_in  = num[QUO_W-1:0];
         den_in = den;
         cnt_in = CW'(QUO_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = CROSS_W'(trial - {1'b0, den_ff});
            sh_in  = {sh_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CROSS_W-1:0];
            sh_in  = {sh_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = sh_ff;

endmodule

[hw/rtl/rpnh_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnh_sqrt : digit-by-digit integer square root
// One root bit per cycle; the root is clamped to the offset width.
// ----------------------------------------------------------------------------
module rpnh_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rpnh_pkg::SQV_W-1:0] value,
   output logic                       done,
   output logic [rpnh_pkg::OFS_W-1:0] ofs
);
   import rpnh_pkg::*;

   localparam int CW    = $clog2(ROOT_W + 1);
   localparam int REM_W = ROOT_W + 5;

   logic [SQV_W-1:0]  v_ff, v_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  trial;
   logic [REM_W-1:0]  test;

   always_comb begin
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[REM_W-3:0], v_ff[SQV_W-1:SQV_W-2]};
      test    = REM_W'({root_ff, 2'b01});
      if (start) begin
         v_in    = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(ROOT_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         v_in = {v_ff[SQV_W-3:0], 2'b00};
         if (trial >= test) begin
            rem_in  = trial - test;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign ofs  = (|root_ff[ROOT_W-1:OFS_W]) ? {OFS_W{1'b1}} : root_ff[OFS_W-1:0];

endmodule

[hw/rtl/ray_polygon_nearest_hit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_polygon_nearest_hit : nearest strict crossing of a ray with a polygon
// Sequencer around one shared multiplier, a divider and a square-root unit.
// ----------------------------------------------------------------------------
//
//   channel  | ports                          | flow
//   ---------+--------------------------------+-------------------------------
//   request  | start, busy, req_data          | word taken when start & !busy
//   result   | rsp_valid, rsp_data            | one-cycle strobe, no back-off
//   control  | csr_we, csr_index, csr_wdata   | write taken when csr_we is high
//
// A load word writes one vertex into the store and gives no result. A cast
// word walks every closed edge of the polygon through the shared multiplier;
// an edge that is crossed takes two 34-step divisions for the crossing point.
// A cast that hits ends with a 34-step square root for the wall offset. Busy
// stays high for the whole cast.
// Reset is synchronous and returns the sequencer to idle, the vertex count to
// four and the position to zero; the vertex store keeps its contents.
// The receiver cannot stall: each result word is shown for exactly one cycle.
//
module ray_polygon_nearest_hit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  rpnh_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output rpnh_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [rpnh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpnh_pkg::CSR_W-1:0]      csr_wdata
);
   import rpnh_pkg::*;

   // Sequencer states, one-hot.
   typedef enum logic [25:0] {
      ST_IDLE  = 26'b1 << 0,
      ST_INIT  = 26'b1 << 1,
      ST_SQ0   = 26'b1 << 2,
      ST_SQ1   = 26'b1 << 3,
      ST_SQ2   = 26'b1 << 4,
      ST_RDC   = 26'b1 << 5,
      ST_LDC   = 26'b1 << 6,
      ST_RDD   = 26'b1 << 7,
      ST_LDD   = 26'b1 << 8,
      ST_CA    = 26'b1 << 9,
      ST_CB    = 26'b1 << 10,
      ST_CC    = 26'b1 << 11,
      ST_CD    = 26'b1 << 12,
      ST_CE    = 26'b1 << 13,
      ST_QA    = 26'b1 << 14,
      ST_QB    = 26'b1 << 15,
      ST_QC    = 26'b1 << 16,
      ST_QD    = 26'b1 << 17,
      ST_NM0   = 26'b1 << 18,
      ST_NM1   = 26'b1 << 19,
      ST_NM2   = 26'b1 << 20,
      ST_DIVW  = 26'b1 << 21,
      ST_NEXT  = 26'b1 << 22,
      ST_FIN   = 26'b1 << 23,
      ST_SQRTW = 26'b1 << 24,
      ST_DONE  = 26'b1 << 25
   } state_type;

   // Which vector the squaring states work on.
   typedef enum logic [1:0] {
      SQ_BEST = 2'd0,
      SQ_HIT  = 2'd1,
      SQ_WALL = 2'd2
   } sq_type;

   state_type          state_ff, state_in;
   sq_type             sq_sel_ff, sq_sel_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   coord_type          posx_ff, posx_in, posy_ff, posy_in;
   coord_type          ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   coord_type          px_ff, px_in, py_ff, py_in, hx_ff, hx_in, hy_ff, hy_in;
   coord_type          cx_ff, cx_in, cy_ff, cy_in, dx_ff, dx_in, dy_ff, dy_in;
   coord_type          wsx_ff, wsx_in, wsy_ff, wsy_in, wex_ff, wex_in, wey_ff, wey_in;
   diff_type           ux_ff, ux_in, uy_ff, uy_in, wx_ff, wx_in, wy_ff, wy_in;
   logic [CNT_W-1:0]   n_ff, n_in, k_ff, k_in;
   logic               hit_ff, hit_in, axis_ff, axis_in;
   prod_type           acc_ff, acc_in;
   cross_type          c1_ff, c1_in, q1_ff, q1_in;
   logic [CROSS_W-1:0] m1_ff, m1_in, den_ff, den_in;
   logic [SQV_W-1:0]   bestd_ff, bestd_in;
   logic [OFS_W-1:0]   ofs_ff, ofs_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   op_type             op_a, op_b;
   prod_type           prod;
   cross_type          cross_v;
   logic [CROSS_W-1:0] abs_c, abs_q1;
   logic [SQV_W-1:0]   sum_sq;
   diff_type           sqa, sqb, u_sel;
   logic [DIFF_W-1:0]  u_mag, q_ext;
   logic [NUM_W-1:0]   num;
   logic [CNT_W-1:0]   nm1, n_sat;
   logic [IDX_W-1:0]   vs_raddr;
   logic               vs_we;
   coord_type          vs_x, vs_y;
   logic               div_start, div_done;
   logic [QUO_W-1:0]   div_quo;
   logic               sqrt_start, sqrt_done;
   logic [OFS_W-1:0]   sqrt_ofs;
   logic               accept;

   rpnh_vstore u_vstore (
      .clock   (clock),
      .we      (vs_we),
      .waddr   (IDX_W'(req_data.vertex_index)),
      .wdata_x (req_data.vertex_x),
      .wdata_y (req_data.vertex_y),
      .raddr   (vs_raddr),
      .rdata_x (vs_x),
      .rdata_y (vs_y)
   );

   rpnh_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   rpnh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   rpnh_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sum_sq),
      .done  (sqrt_done),
      .ofs   (sqrt_ofs)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign vs_we  = accept && (req_data.kind == KIND_LOAD) &&
                   (int'(req_data.vertex_index) < MAX_VERTICES);

   // Shared arithmetic around the registered product.
   assign cross_v = CROSS_W'(acc_ff - prod);
   assign sum_sq  = SQV_W'(acc_ff + prod);
   assign abs_c   = cross_v[CROSS_W-1] ? CROSS_W'(-cross_v) : cross_v;
   assign abs_q1  = q1_ff[CROSS_W-1] ? CROSS_W'(-q1_ff) : q1_ff;
   assign u_sel   = axis_ff ? uy_ff : ux_ff;
   assign u_mag   = u_sel[DIFF_W-1] ? DIFF_W'(-u_sel) : u_sel;
   assign num     = NUM_W'(acc_ff) + (NUM_W'(prod) << HALF_W);
   assign q_ext   = DIFF_W'(div_quo);
   assign nm1     = n_ff - CNT_W'(1);
   assign n_sat   = (int'(count_ff) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                    : CNT_W'(count_ff);

   always_comb begin
      case (sq_sel_ff)
         SQ_BEST: begin
            sqa = dif(px_ff, ax_ff);
            sqb = dif(py_ff, ay_ff);
         end
         SQ_HIT: begin
            sqa = dif(hx_ff, ax_ff);
            sqb = dif(hy_ff, ay_ff);
         end
         SQ_WALL: begin
            sqa = dif(wex_ff, px_ff);
            sqb = dif(wey_ff, py_ff);
         end
         default: begin
            sqa = '0;
            sqb = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sq_sel_in    = sq_sel_ff;
      count_in     = count_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      wsx_in       = wsx_ff;
      wsy_in       = wsy_ff;
      wex_in       = wex_ff;
      wey_in       = wey_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      hit_in       = hit_ff;
      axis_in      = axis_ff;
      acc_in       = acc_ff;
      c1_in        = c1_ff;
      q1_in        = q1_ff;
      m1_in        = m1_ff;
      den_in       = den_ff;
      bestd_in     = bestd_ff;
      ofs_in       = ofs_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      op_a         = '0;
      op_b         = '0;
      vs_raddr     = k_ff[IDX_W-1:0];
      div_start    = 1'b0;
      sqrt_start   = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            CSR_POS_X:        posx_in  = csr_wdata;
            CSR_POS_Y:        posy_in  = csr_wdata;
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.kind == KIND_CAST) begin
               ax_in    = req_data.ray_start_x;
               ay_in    = req_data.ray_start_y;
               bx_in    = req_data.ray_end_x;
               by_in    = req_data.ray_end_y;
               px_in    = req_data.best_x;
               py_in    = req_data.best_y;
               wsx_in   = '0;
               wsy_in   = '0;
               wex_in   = '0;
               wey_in   = '0;
               ofs_in   = '0;
               hit_in   = 1'b0;
               k_in     = '0;
               n_in     = n_sat;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            ux_in     = dif(bx_ff, ax_ff);
            uy_in     = dif(by_ff, ay_ff);
            sq_sel_in = SQ_BEST;
            state_in  = ST_SQ0;
         end
         // Squared length of the selected vector: two products and a sum.
         ST_SQ0: begin
            op_a     = MUL_W'(sqa);
            op_b     = MUL_W'(sqa);
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            acc_in   = prod;
            op_a     = MUL_W'(sqb);
            op_b     = MUL_W'(sqb);
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            case (sq_sel_ff)
               SQ_BEST: begin
                  bestd_in = sum_sq;
                  state_in = (n_ff < CNT_W'(2)) ? ST_FIN : ST_RDC;
               end
               SQ_HIT: begin
                  // Only a strictly nearer crossing wins, so ties keep the earlier edge.
                  if (bestd_ff > sum_sq) begin
                     bestd_in = sum_sq;
                     hit_in   = 1'b1;
                     px_in    = hx_ff;
                     py_in    = hy_ff;
                     wsx_in   = cx_ff;
                     wsy_in   = cy_ff;
                     wex_in   = dx_ff;
                     wey_in   = dy_ff;
                  end
                  state_in = ST_NEXT;
               end
               default: begin
                  sqrt_start = 1'b1;
                  state_in   = ST_SQRTW;
               end
            endcase
         end
         // The closing edge starts at the last vertex in use.
         ST_RDC: begin
            vs_raddr = nm1[IDX_W-1:0];
            state_in = ST_LDC;
         end
         ST_LDC: begin
            cx_in    = sat_add(posx_ff, vs_x);
            cy_in    = sat_add(posy_ff, vs_y);
            state_in = ST_RDD;
         end
         ST_RDD: begin
            vs_raddr = k_ff[IDX_W-1:0];
            state_in = ST_LDD;
         end
         ST_LDD: begin
            dx_in    = sat_add(posx_ff, vs_x);
            dy_in    = sat_add(posy_ff, vs_y);
            state_in = ST_CA;
         end
         // Sides of C and D against the ray line.
         ST_CA: begin
            wx_in    = dif(dx_ff, cx_ff);
            wy_in    = dif(dy_ff, cy_ff);
            op_a     = MUL_W'(ux_ff);
            op_b     = MUL_W'(dif(cy_ff, ay_ff));
            state_in = ST_CB;
         end
         ST_CB: begin
            acc_in   = prod;
            op_a     = MUL_W'(uy_ff);
            op_b     = MUL_W'(dif(cx_ff, ax_ff));
            state_in = ST_CC;
         end
         ST_CC: begin
            c1_in    = cross_v;
            op_a     = MUL_W'(ux_ff);
            op_b     = MUL_W'(dif(dy_ff, ay_ff));
            state_in = ST_CD;
         end
         ST_CD: begin
            acc_in   = prod;
            op_a     = MUL_W'(uy_ff);
            op_b     = MUL_W'(dif(dx_ff, ax_ff));
            state_in = ST_CE;
         end
         // Sides of A and B against the edge line.
         ST_CE: begin
            op_a     = MUL_W'(wx_ff);
            op_b     = MUL_W'(dif(ay_ff, cy_ff));
            state_in = opposite(c1_ff, cross_v) ? ST_QA : ST_NEXT;
         end
         ST_QA: begin
            acc_in   = prod;
            op_a     = MUL_W'(wy_ff);
            op_b     = MUL_W'(dif(ax_ff, cx_ff));
            state_in = ST_QB;
         end
         ST_QB: begin
            q1_in    = cross_v;
            op_a     = MUL_W'(wx_ff);
            op_b     = MUL_W'(dif(by_ff, cy_ff));
            state_in = ST_QC;
         end
         ST_QC: begin
            acc_in   = prod;
            op_a     = MUL_W'(wy_ff);
            op_b     = MUL_W'(dif(bx_ff, cx_ff));
            state_in = ST_QD;
         end
         ST_QD: begin
            if (opposite(q1_ff, cross_v)) begin
               m1_in    = abs_q1;
               den_in   = abs_q1 + abs_c;
               axis_in  = 1'b0;
               state_in = ST_NM0;
            end else begin
               state_in = ST_NEXT;
            end
         end
         // Numerator |u| * |q1| in two half products, then the division.
         ST_NM0: begin
            op_a     = op_type'(u_mag);
            op_b     = op_type'(m1_ff[HALF_W-1:0]);
            state_in = ST_NM1;
         end
         ST_NM1: begin
            acc_in   = prod;
            op_a     = op_type'(u_mag);
            op_b     = op_type'(m1_ff[CROSS_W-1:HALF_W]);
            state_in = ST_NM2;
         end
         ST_NM2: begin
            div_start = 1'b1;
            state_in  = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               if (!axis_ff) begin
                  hx_in    = COORD_W'(DIFF_W'(ax_ff) +
                                      (u_sel[DIFF_W-1] ? DIFF_W'(-q_ext) : q_ext));
                  axis_in  = 1'b1;
                  state_in = ST_NM0;
               end else begin
                  hy_in     = COORD_W'(DIFF_W'(ay_ff) +
                                       (u_sel[DIFF_W-1] ? DIFF_W'(-q_ext) : q_ext));
                  sq_sel_in = SQ_HIT;
                  state_in  = ST_SQ0;
               end
            end
         end
         ST_NEXT: begin
            cx_in    = dx_ff;
            cy_in    = dy_ff;
            k_in     = k_ff + CNT_W'(1);
            state_in = (k_in == n_ff) ? ST_FIN : ST_RDD;
         end
         ST_FIN: begin
            if (hit_ff) begin
               sq_sel_in = SQ_WALL;
               state_in  = ST_SQ0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SQRTW: begin
            if (sqrt_done) begin
               ofs_in   = sqrt_ofs;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.hit          = hit_ff;
            rsp_data_in.hit_x        = px_ff;
            rsp_data_in.hit_y        = py_ff;
            rsp_data_in.wall_start_x = wsx_ff;
            rsp_data_in.wall_start_y = wsy_ff;
            rsp_data_in.wall_end_x   = wex_ff;
            rsp_data_in.wall_end_y   = wey_ff;
            rsp_data_in.wall_offset  = ofs_ff;
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sq_sel_ff   <= sq_sel_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      wsx_ff      <= wsx_in;
      wsy_ff      <= wsy_in;
      wex_ff      <= wex_in;
      wey_ff      <= wey_in;
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      hit_ff      <= hit_in;
      axis_ff     <= axis_in;
      acc_ff      <= acc_in;
      c1_ff       <= c1_in;
      q1_ff       <= q1_in;
      m1_ff       <= m1_in;
      den_ff      <= den_in;
      bestd_ff    <= bestd_in;
      ofs_ff      <= ofs_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_W'(4);
         posx_ff      <= '0;
         posy_ff      <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         posx_ff      <= posx_in;
         posy_ff      <= posy_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result word is a single-cycle strobe.
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result word only follows the end of a cast.
   a_rsp_after_cast : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE))
      else $error("result word without a finished cast");

   // A miss reports no wall.
   a_miss_no_wall : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.wall_offset == '0 &&
                                        rsp_data.wall_end_x == '0 &&
                                        rsp_data.wall_start_x == '0))
      else $error("miss reported with wall fields set");

   // The edge walk never runs past the vertex count.
   a_walk_bound : assert property (@(posedge clock) disable iff (reset)
      k_ff <= n_ff)
      else $error("edge counter beyond vertex count");

endmodule
